>>> rtl/sts_pkg.sv
package sts_pkg;

  // coordinate format
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = COORD_BITS - 2;
  localparam int GUARD_BITS = 26 - COORD_BITS;
  localparam int MAX_DEPTH  = 3;

  // sum of two corners, its square norm and the root
  localparam int SUM_W  = COORD_BITS + 1;
  localparam int N2_W   = 2 * SUM_W;
  localparam int RAD_W  = N2_W + 2 * GUARD_BITS;
  localparam int ROOT_W = RAD_W / 2;

  // divider: numerator = (mag << (FRAC+G+1)) + d, divisor = 2d
  localparam int NUM_W = SUM_W + FRAC_BITS + GUARD_BITS + 1;
  localparam int DEN_W = ROOT_W + 1;
  localparam int QUO_W = COORD_BITS + 2;

  // shared multiplier operands
  localparam int MUL_W  = 18;
  localparam int PROD_W = 2 * MUL_W;
  localparam int OUT_W  = 32;

  // vertex store: six entries per level
  localparam int VTX_W     = 3 * COORD_BITS;
  localparam int MEM_DEPTH = 6 * (MAX_DEPTH + 1);
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int LVL_W     = 2;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_RADIUS = 1'b0,
    CFG_DEPTH  = 1'b1
  } cfg_idx_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // one component out of a packed vertex (x low, z high)
  function automatic coord_t get_comp(input logic [VTX_W-1:0] v, input logic [1:0] c);
    coord_t r;
    unique case (c)
      2'd0:    r = v[COORD_BITS-1:0];
      2'd1:    r = v[2*COORD_BITS-1:COORD_BITS];
      default: r = v[3*COORD_BITS-1:2*COORD_BITS];
    endcase
    return r;
  endfunction

  // child corner sources (slot within the level)
  function automatic logic [2:0] child_src(input logic [1:0] k, input logic [1:0] j);
    logic [2:0] r;
    unique case ({k, j})
      4'b0000: r = 3'd0;
      4'b0001: r = 3'd3;
      4'b0010: r = 3'd5;
      4'b0100: r = 3'd1;
      4'b0101: r = 3'd4;
      4'b0110: r = 3'd3;
      4'b1000: r = 3'd2;
      4'b1001: r = 3'd5;
      4'b1010: r = 3'd4;
      4'b1100: r = 3'd3;
      4'b1101: r = 3'd4;
      4'b1110: r = 3'd5;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // edge endpoints of midpoint m: ab, bc, ac
  function automatic logic [2:0] mid_p(input logic [1:0] m);
    return (m == 2'd1) ? 3'd1 : 3'd0;
  endfunction

  function automatic logic [2:0] mid_q(input logic [1:0] m);
    return (m == 2'd0) ? 3'd1 : 3'd2;
  endfunction

  // leaf corner order a, c, b
  function automatic logic [2:0] leaf_ord(input logic [1:0] v);
    logic [2:0] r;
    unique case (v)
      2'd0:    r = 3'd0;
      2'd1:    r = 3'd2;
      default: r = 3'd1;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/sts_sqrt.sv
module sts_sqrt
  import sts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  // one result bit per cycle, two radicand bits brought down
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
  assign trial  = REM_W'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> rtl/sts_div.sv
module sts_div
  import sts_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int REM_W = DEN_W + 1;
  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [QUO_W-1:0] low_r;
  logic [REM_W-1:0] rem_r;
  logic [QUO_W-1:0] quo_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [REM_W-1:0] rem_sh;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_r[REM_W-2:0], low_r[QUO_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(QUO_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath; the quotient fits in QUO_W bits for every midpoint
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= REM_W'(num[NUM_W-1:QUO_W]);
      low_r <= num[QUO_W-1:0];
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      low_r <= {low_r[QUO_W-2:0], 1'b0};
      if (rem_sh >= REM_W'(den_r)) begin
        rem_r <= rem_sh - REM_W'(den_r);
        quo_r <= {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

>>> rtl/sphere_triangle_subdivider.sv
// Triangle subdivider on the unit sphere.
// Input channel (in_*): one beat carries corners a, b, c, signed Q1.14.
// Result channel (out_*): one beat per leaf triangle, corners a, c, b
// times the radius in signed Q9.22; out_last marks the final leaf.
// Config channel (cfg_*): index 0 radius (Q8.8), index 1 depth; always
// ready. The user must write it only while the block is idle; the
// block does not enforce this. One input yields 4^depth result beats.
// The block takes one input at a time: in_ready is high only when the
// previous input has delivered all its beats. Each midpoint goes through
// a shared 18x18 multiplier for the norm, a 27-step bit-serial square
// root and three 18-step bit-serial divides, three midpoints per split
// node; the root and the divides are skipped when the edge sum is zero.
// Each leaf reads its three corners from the vertex store and scales
// them one component at a time, then sends the output beat and passes
// through the return state; each child copy moves three corners. While
// out_valid waits for out_ready the traversal holds; nothing is dropped.
// Synchronous active-low reset returns to idle with radius 1.0 and depth
// 1; the vertex store is not cleared, each entry is written before it is
// read.
module sphere_triangle_subdivider
  import sts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [15:0]    in_a_x,
  input  logic signed [15:0]    in_a_y,
  input  logic signed [15:0]    in_a_z,
  input  logic signed [15:0]    in_b_x,
  input  logic signed [15:0]    in_b_y,
  input  logic signed [15:0]    in_b_z,
  input  logic signed [15:0]    in_c_x,
  input  logic signed [15:0]    in_c_y,
  input  logic signed [15:0]    in_c_z,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [31:0]    out_first_x,
  output logic signed [31:0]    out_first_y,
  output logic signed [31:0]    out_first_z,
  output logic signed [31:0]    out_second_x,
  output logic signed [31:0]    out_second_y,
  output logic signed [31:0]    out_second_z,
  output logic signed [31:0]    out_third_x,
  output logic signed [31:0]    out_third_y,
  output logic signed [31:0]    out_third_z,
  output logic                  out_last
);

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_LOAD  = 18'h00002,
    S_NODE  = 18'h00004,
    S_MRDP  = 18'h00008,
    S_MRDQ  = 18'h00010,
    S_MSUM  = 18'h00020,
    S_MSQ   = 18'h00040,
    S_SQGO  = 18'h00080,
    S_SQWT  = 18'h00100,
    S_DVGO  = 18'h00200,
    S_DVWT  = 18'h00400,
    S_MWR   = 18'h00800,
    S_CRD   = 18'h01000,
    S_CWR   = 18'h02000,
    S_LRD   = 18'h04000,
    S_LMUL  = 18'h08000,
    S_OUT   = 18'h10000,
    S_RET   = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0]          radius_r;
  logic [LVL_W-1:0]     depth_r;
  logic [LVL_W-1:0]     lvl_r;
  logic [1:0]           k_r [3];
  logic [1:0]           j_r;
  logic [1:0]           m_r;
  logic [1:0]           v_r;
  coord_t               in_r [9];
  logic [VTX_W-1:0]     vp_r;
  logic signed [SUM_W-1:0] s_r [3];
  logic [N2_W-1:0]      n2_r;
  logic [ROOT_W-1:0]    d_r;
  coord_t               res_r [3];
  logic [OUT_W-1:0]     ov_r [9];
  logic                 last_r;

  // vertex store
  logic [VTX_W-1:0]     vtx_mem [MEM_DEPTH];
  logic [VTX_W-1:0]     rdata_r;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  logic [VTX_W-1:0]     wr_data;

  logic [ADDR_W-1:0]    base;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [OUT_W-1:0]     scaled;
  logic                 sq_start, sq_done, dv_start, dv_done;
  logic [ROOT_W-1:0]    sq_root;
  logic [QUO_W-1:0]     dv_quo;
  logic [SUM_W-1:0]     mag;
  logic signed [SUM_W-1:0] s_sel;
  coord_t               sat_res;
  logic                 leaf_last;
  logic                 up_done;

  assign base = ADDR_W'({lvl_r, 2'b00}) + ADDR_W'({lvl_r, 1'b0});

  // config port
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'd256;
      depth_r  <= LVL_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RADIUS: radius_r <= cfg_data;
        CFG_DEPTH:  depth_r  <= cfg_data[LVL_W-1:0];
        default:    ;
      endcase
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (wr_en) vtx_mem[wr_addr] <= wr_data;
    if (rd_en) rdata_r <= vtx_mem[rd_addr];
  end

  // shared multiplier: norm squares and radius scaling
  always_comb begin
    if (state_r == S_LMUL) begin
      mul_a = MUL_W'(get_comp(rdata_r, j_r));
      mul_b = $signed({2'b00, radius_r});
    end else begin
      mul_a = MUL_W'(s_sel);
      mul_b = MUL_W'(s_sel);
    end
  end
  assign prod = mul_a * mul_b;

  always_comb begin
    unique case (j_r)
      2'd0:    s_sel = s_r[0];
      2'd1:    s_sel = s_r[1];
      default: s_sel = s_r[2];
    endcase
  end

  // saturate scaled product to 32 bits
  always_comb begin
    if (prod > PROD_W'(64'sh7fff_ffff))
      scaled = 32'h7fff_ffff;
    else if (prod < -PROD_W'(64'sh8000_0000))
      scaled = 32'h8000_0000;
    else
      scaled = prod[OUT_W-1:0];
  end

  // iterative units
  assign mag = s_sel[SUM_W-1] ? SUM_W'(-s_sel) : SUM_W'(s_sel);

  sts_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand ({n2_r, {(2*GUARD_BITS){1'b0}}}),
    .done     (sq_done),
    .root     (sq_root)
  );

  sts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   ({mag, {(FRAC_BITS+GUARD_BITS+1){1'b0}}} + NUM_W'(d_r)),
    .den   ({d_r, 1'b0}),
    .done  (dv_done),
    .quo   (dv_quo)
  );

  assign sq_start = (state_r == S_SQGO);
  assign dv_start = (state_r == S_DVGO);

  // round result back to a signed coordinate with saturation
  always_comb begin
    if (s_sel[SUM_W-1]) begin
      if (dv_quo > QUO_W'(2**(COORD_BITS-1)))
        sat_res = coord_t'(1 << (COORD_BITS-1));
      else
        sat_res = -coord_t'(dv_quo[COORD_BITS-1:0]);
    end else begin
      if (dv_quo > QUO_W'(2**(COORD_BITS-1) - 1))
        sat_res = coord_t'((1 << (COORD_BITS-1)) - 1);
      else
        sat_res = coord_t'(dv_quo[COORD_BITS-1:0]);
    end
  end

  // final leaf: every open level is on its last child
  always_comb begin
    leaf_last = 1'b1;
    for (int i = 0; i < 3; i++)
      if (LVL_W'(i) < lvl_r && k_r[i] != 2'd3) leaf_last = 1'b0;
  end

  assign up_done = (k_r[lvl_r - 1'b1] == 2'd3);

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = base;
    wr_en   = 1'b0;
    wr_addr = base;
    wr_data = {res_r[2], res_r[1], res_r[0]};
    unique case (state_r)
      S_LOAD: begin
        wr_en   = 1'b1;
        wr_addr = ADDR_W'(j_r);
        wr_data = {in_r[4'(j_r) * 4'd3 + 4'd2], in_r[4'(j_r) * 4'd3 + 4'd1],
                   in_r[4'(j_r) * 4'd3]};
      end
      S_MRDP: begin
        rd_en   = 1'b1;
        rd_addr = base + ADDR_W'(mid_p(m_r));
      end
      S_MRDQ: begin
        rd_en   = 1'b1;
        rd_addr = base + ADDR_W'(mid_q(m_r));
      end
      S_MWR: begin
        wr_en   = 1'b1;
        wr_addr = base + ADDR_W'(m_r) + ADDR_W'(3);
      end
      S_CRD: begin
        rd_en   = 1'b1;
        rd_addr = base + ADDR_W'(child_src(k_r[lvl_r], j_r));
      end
      S_CWR: begin
        wr_en   = 1'b1;
        wr_addr = base + ADDR_W'(j_r) + ADDR_W'(6);
        wr_data = rdata_r;
      end
      S_LRD: begin
        rd_en   = 1'b1;
        rd_addr = base + ADDR_W'(leaf_ord(v_r));
      end
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_LOAD;
      S_LOAD: if (j_r == 2'd2) state_nxt = S_NODE;
      S_NODE: state_nxt = (lvl_r == depth_r) ? S_LRD : S_MRDP;
      S_MRDP: state_nxt = S_MRDQ;
      S_MRDQ: state_nxt = S_MSUM;
      S_MSUM: state_nxt = S_MSQ;
      S_MSQ:  if (j_r == 2'd2) state_nxt = S_SQGO;
      S_SQGO: state_nxt = (n2_r == '0) ? S_MWR : S_SQWT;
      S_SQWT: if (sq_done) state_nxt = S_DVGO;
      S_DVGO: state_nxt = S_DVWT;
      S_DVWT: if (dv_done) state_nxt = (j_r == 2'd2) ? S_MWR : S_DVGO;
      S_MWR:  state_nxt = (m_r == 2'd2) ? S_CRD : S_MRDP;
      S_CRD:  state_nxt = S_CWR;
      S_CWR:  state_nxt = (j_r == 2'd2) ? S_NODE : S_CRD;
      S_LRD:  state_nxt = S_LMUL;
      S_LMUL: if (j_r == 2'd2) state_nxt = (v_r == 2'd2) ? S_OUT : S_LRD;
      S_OUT:  if (out_ready) state_nxt = S_RET;
      S_RET: begin
        if (lvl_r == '0) state_nxt = S_IDLE;
        else if (!up_done) state_nxt = S_CRD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lvl_r   <= '0;
      j_r     <= '0;
      m_r     <= '0;
      v_r     <= '0;
      for (int i = 0; i < 3; i++) k_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          j_r   <= '0;
          lvl_r <= '0;
        end
        S_LOAD: j_r <= j_r + 1'b1;
        S_NODE: begin
          m_r <= '0;
          v_r <= '0;
          j_r <= '0;
        end
        S_MSUM: j_r <= '0;
        S_MSQ:  j_r <= j_r + 1'b1;
        S_SQGO: j_r <= '0;
        S_DVWT: if (dv_done) j_r <= j_r + 1'b1;
        S_MWR: begin
          j_r <= '0;
          m_r <= m_r + 1'b1;
          if (m_r == 2'd2) k_r[lvl_r] <= '0;
        end
        S_CRD:  ;
        S_CWR: begin
          j_r <= j_r + 1'b1;
          if (j_r == 2'd2) lvl_r <= lvl_r + 1'b1;
        end
        S_LRD:  j_r <= '0;
        S_LMUL: begin
          j_r <= j_r + 1'b1;
          if (j_r == 2'd2) v_r <= v_r + 1'b1;
        end
        S_RET: begin
          j_r <= '0;
          if (lvl_r != '0) begin
            lvl_r <= lvl_r - 1'b1;
            if (!up_done) k_r[lvl_r - 1'b1] <= k_r[lvl_r - 1'b1] + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      in_r[0] <= in_a_x; in_r[1] <= in_a_y; in_r[2] <= in_a_z;
      in_r[3] <= in_b_x; in_r[4] <= in_b_y; in_r[5] <= in_b_z;
      in_r[6] <= in_c_x; in_r[7] <= in_c_y; in_r[8] <= in_c_z;
    end
    if (state_r == S_MRDQ) vp_r <= rdata_r;
    if (state_r == S_MSUM) begin
      for (int i = 0; i < 3; i++)
        s_r[i] <= SUM_W'(get_comp(vp_r, 2'(i))) + SUM_W'(get_comp(rdata_r, 2'(i)));
      n2_r <= '0;
    end
    if (state_r == S_MSQ) n2_r <= n2_r + prod[N2_W-1:0];
    if (state_r == S_SQGO) begin
      for (int i = 0; i < 3; i++) res_r[i] <= '0;
    end
    if (state_r == S_SQWT && sq_done) d_r <= sq_root;
    if (state_r == S_DVWT && dv_done) res_r[j_r] <= sat_res;
    if (state_r == S_LMUL) ov_r[4'(v_r) * 4'd3 + 4'(j_r)] <= scaled;
    if (state_r == S_LRD) last_r <= leaf_last;
  end

  // handshake and result ports
  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = (state_r == S_OUT);
  assign out_first_x  = ov_r[0];
  assign out_first_y  = ov_r[1];
  assign out_first_z  = ov_r[2];
  assign out_second_x = ov_r[3];
  assign out_second_y = ov_r[4];
  assign out_second_z = ov_r[5];
  assign out_third_x  = ov_r[6];
  assign out_third_y  = ov_r[7];
  assign out_third_z  = ov_r[8];
  assign out_last     = last_r;

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result beat is pending");

  a_lvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= depth_r)
    else $error("traversal level beyond depth");

  a_idle_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> lvl_r == '0 || state_r == S_RET)
    else $error("last beat left open levels");

  // the block passes the return state once per open level before idle
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> ##[1:4] in_ready)
    else $error("block not idle after final beat");

endmodule
